[sv/cu_pkg.sv]
`default_nettype none
package cu_pkg;

  localparam int MaxN = 32;
  localparam int MaxK = 16;

  localparam int RankW    = 30;
  localparam int ElemW    = 5;
  localparam int SetW     = 6;
  localparam int SubW     = 5;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 6;

  localparam int BinomW  = RankW;
  localparam int TabRows = MaxN + 1;
  localparam int TabCols = MaxK + 1;
  localparam int RowW    = $clog2(TabRows);
  localparam int ColW    = $clog2(TabCols);
  localparam int AW      = $clog2(MaxN);
  localparam int BW      = $clog2(MaxK);

  typedef logic [TabRows-1:0][TabCols-1:0][BinomW-1:0] binom_tab_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SET_SIZE    = 2'd0,
    CFG_SUBSET_SIZE = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_ERR
  } state_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_SKIP,
    OP_TAKE
  } op_e;

  typedef struct packed {
    logic             bad_cfg;
    logic             lt;
    logic             diag;
    logic             b_zero;
    logic [ElemW-1:0] elem;
  } dp_stat_t;

  typedef struct packed {
    op_e  op;
    logic emit;
    logic err;
  } seq_ctl_t;

  // Pascal triangle, columns 0..MaxK, built at elaboration
  function automatic binom_tab_t build_binom();
    binom_tab_t t;
    t = '0;
    for (int a = 0; a < TabRows; a++) begin
      t[a][0] = BinomW'(1);
      for (int b = 1; b < TabCols; b++) begin
        if (b <= a) begin
          t[a][b] = t[a-1][b-1] + ((b < a) ? t[a-1][b] : '0);
        end
      end
    end
    return t;
  endfunction

  localparam binom_tab_t BinomTab = build_binom();

endpackage
`default_nettype wire

[sv/cu_if.sv]
`default_nettype none
interface cu_req_if import cu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RankW-1:0] rank;

  modport source (output valid, output rank, input ready);
  modport sink   (input valid, input rank, output ready);
endinterface

interface cu_res_if import cu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ElemW-1:0] element;
  logic             last;
  logic             error;

  modport source (output valid, output element, output last, output error, input ready);
  modport sink   (input valid, input element, input last, input error, output ready);
endinterface
`default_nettype wire

[sv/cu_binom_rom.sv]
`default_nettype none
module cu_binom_rom import cu_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic [RowW-1:0]   row_i,
  input  wire logic [ColW-1:0]   col_i,
  output logic      [BinomW-1:0] data_o
);

  logic [BinomW-1:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= BinomTab[row_i][col_i];
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

[sv/cu_walk.sv]
`default_nettype none
module cu_walk import cu_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic [SetW-1:0]  set_size_i,
  input  wire logic [SubW-1:0]  subset_size_i,
  input  wire logic [RankW-1:0] rank_i,
  input  wire op_e              op_i,
  output dp_stat_t              stat_o
);

  logic [RankW-1:0]  rem_q, rem_d;
  logic [AW-1:0]     a_q, a_d;
  logic [BW-1:0]     b_q, b_d;
  logic [ElemW-1:0]  j_q, j_d;
  logic [BinomW-1:0] c;
  logic [RowW-1:0]   rd_row;
  logic [ColW-1:0]   rd_col;
  logic              bad_cfg;

  assign bad_cfg = (set_size_i > SetW'(MaxN)) || (subset_size_i > SubW'(MaxK)) ||
                   (subset_size_i == '0) || (SetW'(subset_size_i) > set_size_i);

  always_comb begin
    rem_d = rem_q;
    a_d   = a_q;
    b_d   = b_q;
    j_d   = j_q;
    case (op_i)
      OP_LOAD: begin
        rem_d = rank_i;
        a_d   = AW'(set_size_i - SetW'(1));
        b_d   = BW'(subset_size_i - SubW'(1));
        j_d   = '0;
      end
      OP_SKIP: begin
        rem_d = rem_q - c;
        a_d   = a_q - AW'(1);
        j_d   = j_q + ElemW'(1);
      end
      OP_TAKE: begin
        a_d = a_q - AW'(1);
        b_d = b_q - BW'(1);
        j_d = j_q + ElemW'(1);
      end
      default: ;
    endcase
  end

  // first lookup is C(n,k) for the range check, then C(a,b) of the next candidate
  always_comb begin
    if (op_i == OP_LOAD) begin
      rd_row = bad_cfg ? '0 : RowW'(set_size_i);
      rd_col = bad_cfg ? '0 : ColW'(subset_size_i);
    end else begin
      rd_row = RowW'(a_d);
      rd_col = ColW'(b_d);
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    a_q   <= a_d;
    b_q   <= b_d;
    j_q   <= j_d;
  end

  cu_binom_rom u_rom (
    .clk_i  (clk_i),
    .row_i  (rd_row),
    .col_i  (rd_col),
    .data_o (c)
  );

  assign stat_o.bad_cfg = bad_cfg;
  assign stat_o.lt      = rem_q < c;
  assign stat_o.diag    = (a_q == AW'(b_q));
  assign stat_o.b_zero  = (b_q == '0);
  assign stat_o.elem    = j_q;

endmodule
`default_nettype wire

[sv/cu_seq.sv]
`default_nettype none
module cu_seq import cu_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     req_valid_i,
  input  wire logic     can_emit_i,
  input  wire dp_stat_t stat_i,
  output logic          req_ready_o,
  output seq_ctl_t      ctl_o
);

  state_e st_q, st_d;
  logic   take;

  assign take = stat_i.diag || stat_i.lt;

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          st_d = stat_i.bad_cfg ? ST_ERR : ST_CHECK;
        end
      end
      ST_CHECK: begin
        st_d = stat_i.lt ? ST_WALK : ST_ERR;
      end
      ST_WALK: begin
        if (take && can_emit_i && stat_i.b_zero) begin
          st_d = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (can_emit_i) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o = 1'b0;
    ctl_o.op    = OP_HOLD;
    ctl_o.emit  = 1'b0;
    ctl_o.err   = 1'b0;
    case (st_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          ctl_o.op = OP_LOAD;
        end
      end
      ST_CHECK: ;
      ST_WALK: begin
        if (!take) begin
          ctl_o.op = OP_SKIP;
        end else if (can_emit_i) begin
          ctl_o.op   = OP_TAKE;
          ctl_o.emit = 1'b1;
        end
      end
      ST_ERR: begin
        ctl_o.err  = 1'b1;
        ctl_o.emit = can_emit_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

endmodule
`default_nettype wire

[sv/combination_unrank.sv]
// channel  | dir | handshake     | payload
// req_i    | in  | valid / ready | rank[29:0]
// res_o    | out | valid / ready | element[4:0], last, error
// cfg      | in  | cfg_we_i      | cfg_idx_i (0 set_size, 1 subset_size), cfg_wdata_i
//
// An item goes through a load step and a range check step, then walks the
// candidate positions, at most n; an error item leaves from load or check.
// The walk rate is set by the registered binomial ROM read, one lookup a cycle.
// A full output register that is not taken stalls the walk at the next element.
// Reset clears the sequencer, the output valid and the config (n = 1, k = 1).
`default_nettype none
module combination_unrank import cu_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  cu_req_if.sink                   req_i,
  cu_res_if.source                 res_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  logic [SetW-1:0]  set_size_q;
  logic [SubW-1:0]  subset_size_q;
  dp_stat_t         stat;
  seq_ctl_t         ctl;
  logic             can_emit;
  logic             out_valid_q;
  logic [ElemW-1:0] out_elem_q;
  logic             out_last_q;
  logic             out_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_size_q    <= SetW'(1);
      subset_size_q <= SubW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SET_SIZE:    set_size_q    <= SetW'(cfg_wdata_i);
        CFG_SUBSET_SIZE: subset_size_q <= SubW'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  assign can_emit = !out_valid_q || res_o.ready;

  cu_walk u_walk (
    .clk_i         (clk_i),
    .set_size_i    (set_size_q),
    .subset_size_i (subset_size_q),
    .rank_i        (req_i.rank),
    .op_i          (ctl.op),
    .stat_o        (stat)
  );

  cu_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .can_emit_i  (can_emit),
    .stat_i      (stat),
    .req_ready_o (req_i.ready),
    .ctl_o       (ctl)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.emit) begin
      out_elem_q <= ctl.err ? '0 : stat.elem;
      out_last_q <= ctl.err || stat.b_zero;
      out_err_q  <= ctl.err;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.element = out_elem_q;
  assign res_o.last    = out_last_q;
  assign res_o.error   = out_err_q;

endmodule
`default_nettype wire

[sv/cu_checker.sv]
`default_nettype none
module cu_checker import cu_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             req_valid_i,
  input wire logic             req_ready_i,
  input wire logic             res_valid_i,
  input wire logic             res_ready_i,
  input wire logic [ElemW-1:0] res_element_i,
  input wire logic             res_last_i,
  input wire logic             res_error_i
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_element_i) &&
    $stable(res_last_i) && $stable(res_error_i))
    else $error("result word changed while stalled");

  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_error_i |-> res_last_i && (res_element_i == '0))
    else $error("error word not last or element nonzero");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken back to back");

  a_busy_mid_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_last_i |-> !req_ready_i)
    else $error("request ready before subset finished");

endmodule

bind combination_unrank cu_checker u_cu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_element_i (res_o.element),
  .res_last_i    (res_o.last),
  .res_error_i   (res_o.error)
);
`default_nettype wire

[dv/tb_combination_unrank.sv]
`timescale 1ns / 1ps
module tb_combination_unrank;
  import cu_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam int NumDir     = 24;
  localparam int NumPhases  = 14;
  localparam int PhaseItems = 25;

  typedef struct packed {
    logic [ElemW-1:0] element;
    logic             last;
    logic             error;
  } subset_word_t;

  typedef enum logic [1:0] {
    CHK_PRED,
    CHK_ERR,
    CHK_RUN
  } row_chk_e;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_BEAT,
    RX_TRICKLE
  } rx_mode_e;

  typedef struct {
    int       n;
    int       k;
    int       rank;
    row_chk_e chk;
    int       base;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  cu_req_if req_if ();
  cu_res_if res_if ();

  combination_unrank uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // run of rank 0 is 0..k-1, top rank is n-k..n-1
  dir_row_t dir_rows [0:NumDir-1] = '{
    '{1,  1,  0,          CHK_RUN,  0},
    '{1,  1,  1,          CHK_ERR,  0},
    '{32, 16, 0,          CHK_RUN,  0},
    '{32, 16, 601080389,  CHK_RUN,  16},
    '{32, 16, 601080390,  CHK_ERR,  0},
    '{32, 16, 1073741823, CHK_ERR,  0},
    '{32, 16, 357913941,  CHK_PRED, 0},
    '{32, 16, 715827882,  CHK_ERR,  0},
    '{32, 1,  31,         CHK_RUN,  31},
    '{32, 1,  32,         CHK_ERR,  0},
    '{32, 15, 123456789,  CHK_PRED, 0},
    '{10, 3,  57,         CHK_PRED, 0},
    '{10, 3,  119,        CHK_RUN,  7},
    '{6,  3,  10,         CHK_PRED, 0},
    '{16, 16, 0,          CHK_RUN,  0},
    '{16, 16, 1,          CHK_ERR,  0},
    '{5,  6,  0,          CHK_ERR,  0},
    '{5,  0,  0,          CHK_ERR,  0},
    '{0,  1,  0,          CHK_ERR,  0},
    '{33, 1,  0,          CHK_ERR,  0},
    '{63, 31, 0,          CHK_ERR,  0},
    '{20, 17, 0,          CHK_ERR,  0},
    '{31, 31, 0,          CHK_ERR,  0},
    '{2,  1,  1,          CHK_RUN,  1}
  };

  bit [SetW-1:0]  cur_set = 1;
  bit [SubW-1:0]  cur_sub = 1;
  subset_word_t   pending_elems [$];
  subset_word_t   want_word;
  subset_word_t   got_word;
  int             mismatch_count = 0;
  int             cycle_count = 0;
  int             burst_left = 0;
  bit             sender_bursty = 1'b1;
  rx_mode_e       rx_mode = RX_OPEN;
  int             rx_timer = 0;
  logic [7:0]     rx_beat = '0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint unsigned choose(int a, int b);
    longint unsigned acc;
    acc = 1;
    if (b < 0 || b > a) return 0;
    for (int i = 1; i <= b; i++) acc = acc * longint'(a - b + i) / longint'(i);
    return acc;
  endfunction

  function automatic longint unsigned subset_count();
    if (cur_set > MaxN || cur_sub == 0 || cur_sub > MaxK || cur_sub > cur_set) return 0;
    return choose(cur_set, cur_sub);
  endfunction

  function automatic void queue_word(subset_word_t w);
    pending_elems.insert(pending_elems.size(), w);
  endfunction

  function automatic void push_error_word();
    subset_word_t w;
    w.element = '0;
    w.last    = 1'b1;
    w.error   = 1'b1;
    queue_word(w);
  endfunction

  function automatic void unrank_subset(logic [RankW-1:0] rank);
    int              n;
    int              k;
    int              j;
    int              first;
    longint unsigned rem;
    longint unsigned c;
    subset_word_t    w;
    n     = cur_set;
    k     = cur_sub;
    rem   = rank;
    first = 0;
    if (subset_count() == 0 || rem >= subset_count()) begin
      push_error_word();
      return;
    end
    for (int i = 0; i < k; i++) begin
      j = first;
      while (j < n - k + i) begin
        c = choose(n - 1 - j, k - 1 - i);
        if (rem < c) break;
        rem -= c;
        j++;
      end
      w.element = ElemW'(j);
      w.last    = (i == k - 1);
      w.error   = 1'b0;
      queue_word(w);
      first = j + 1;
    end
  endfunction

  task automatic wait_drain();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_elems.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_config(input int n, input int k, input bit spare);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SET_SIZE;
    cfg_wdata_i <= CfgDataW'(n);
    @(negedge clk_i);
    cfg_idx_i   <= CFG_SUBSET_SIZE;
    cfg_wdata_i <= {spare, SubW'(k)};
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_set = SetW'(n);
    cur_sub = SubW'(k);
  endtask

  // bursts of requests, with random gaps in between when the sender is bursty
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = sender_bursty ? $urandom_range(1, 6) : 0;
      repeat (gap) begin
        @(negedge clk_i);
        req_if.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  task automatic send_rank(input logic [RankW-1:0] rank, input row_chk_e chk, input int base);
    subset_word_t w;
    pace();
    @(negedge clk_i);
    req_if.valid <= 1'b1;
    req_if.rank  <= rank;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    case (chk)
      CHK_ERR: push_error_word();
      CHK_RUN: begin
        for (int i = 0; i < cur_sub; i++) begin
          w.element = ElemW'(base + i);
          w.last    = (i == cur_sub - 1);
          w.error   = 1'b0;
          queue_word(w);
        end
      end
      default: unrank_subset(rank);
    endcase
  endtask

  always @(negedge clk_i) begin
    if (rx_timer == 0) begin
      rx_mode  <= rx_mode_e'($urandom_range(0, 3));
      rx_timer <= $urandom_range(16, 96);
    end else begin
      rx_timer <= rx_timer - 1;
    end
    rx_beat <= rx_beat + 1'b1;
    case (rx_mode)
      RX_OPEN: res_if.ready <= 1'b1;
      RX_COIN: res_if.ready <= 1'($urandom_range(0, 1));
      RX_BEAT: res_if.ready <= (rx_beat[1:0] != 2'd3);
      default: res_if.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      got_word = {res_if.element, res_if.last, res_if.error};
      if (pending_elems.size() == 0) begin
        $display("%0t: unexpected word element %0d last %0d error %0d", $time,
                 got_word.element, got_word.last, got_word.error);
        mismatch_count++;
      end else begin
        want_word = pending_elems.pop_front();
        if (want_word.element != got_word.element || want_word.last != got_word.last ||
            want_word.error != got_word.error) begin
          $display("%0t: element/last/error expected %0d/%0d/%0d got %0d/%0d/%0d", $time,
                   want_word.element, want_word.last, want_word.error,
                   got_word.element, got_word.last, got_word.error);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int                n_sel;
    int                k_sel;
    int                pick;
    longint unsigned   span;
    logic [RankW-1:0]  rank;
    rst_ni        = 1'b0;
    req_if.valid  <= 1'b0;
    req_if.rank   <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_SET_SIZE;
    cfg_wdata_i   <= '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // first row runs on the reset setting
    for (int r = 0; r < NumDir; r++) begin
      if (dir_rows[r].n != cur_set || dir_rows[r].k != cur_sub) begin
        wait_drain();
        write_config(dir_rows[r].n, dir_rows[r].k, 1'b0);
      end
      send_rank(RankW'(dir_rows[r].rank), dir_rows[r].chk, dir_rows[r].base);
    end

    for (int p = 0; p < NumPhases; p++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        n_sel = MaxN;
        k_sel = $urandom_range(12, MaxK);
      end else if (pick == 1) begin
        n_sel = $urandom_range(0, 63);
        k_sel = $urandom_range(0, 31);
      end else if (pick < 4) begin
        n_sel = $urandom_range(13, MaxN);
        k_sel = $urandom_range(1, MaxK);
      end else begin
        n_sel = $urandom_range(1, 12);
        k_sel = $urandom_range(1, n_sel);
      end
      wait_drain();
      write_config(n_sel, k_sel, 1'($urandom_range(0, 1)));
      sender_bursty = ($urandom_range(0, 3) != 0);
      span = subset_count();
      for (int i = 0; i < PhaseItems; i++) begin
        pick = $urandom_range(0, 19);
        if (span != 0 && pick < 14) rank = RankW'($urandom_range(0, 32'(span - 1)));
        else if (span != 0 && pick < 17) rank = RankW'(span - 1 + $urandom_range(0, 1));
        else rank = RankW'($urandom());
        if ($urandom_range(0, 39) == 0) wait_drain();
        send_rank(rank, CHK_PRED, 0);
      end
    end

    wait_drain();
    repeat (3 * (MaxN + 2)) @(negedge clk_i);
    if (mismatch_count == 0 && pending_elems.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
